// ===== hdl/rfae_pkg.sv =====
// rfae_pkg: shared types and constants for the register file execute block
// operation codes, register file geometry, instruction and write-back records
// no dependencies
package rfae_pkg;

	localparam int NumRegs     = 13;
	localparam int RegIdxW     = 4;
	localparam int WordW       = 16;
	localparam int ByteW       = 8;
	localparam int WidthW      = 2;
	localparam int OpW         = 2;
	localparam int FlagW       = 2;
	localparam int FlagZeroBit = 0;
	localparam int FlagSignBit = 1;

	typedef enum logic [OpW-1:0] {
		OpMov = 2'd0,
		OpAdd = 2'd1,
		OpSub = 2'd2,
		OpCmp = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [RegIdxW-1:0] dest_reg;
		logic               dest_high_byte;
		logic [WidthW-1:0]  dest_width_bytes;
		logic               src_is_immediate;
		logic [RegIdxW-1:0] src_reg;
		logic               src_high_byte;
		logic [WidthW-1:0]  src_width_bytes;
		logic [WordW-1:0]   immediate_value;
	} item_t;

	typedef struct packed {
		logic               en;
		logic [RegIdxW-1:0] idx;
		logic [WordW-1:0]   word;
	} wr_t;

endpackage

// ===== hdl/rfae_req_if.sv =====
// rfae_req_if: instruction channel, valid/ready plus decoded instruction fields
// depends on rfae_pkg
interface rfae_req_if;

	logic                        valid;
	logic                        ready;
	logic [rfae_pkg::OpW-1:0]    operation;
	logic [rfae_pkg::RegIdxW-1:0] dest_reg;
	logic                        dest_high_byte;
	logic [rfae_pkg::WidthW-1:0] dest_width_bytes;
	logic                        src_is_immediate;
	logic [rfae_pkg::RegIdxW-1:0] src_reg;
	logic                        src_high_byte;
	logic [rfae_pkg::WidthW-1:0] src_width_bytes;
	logic [rfae_pkg::WordW-1:0]  immediate_value;

	modport source (
		output valid, operation, dest_reg, dest_high_byte, dest_width_bytes,
		       src_is_immediate, src_reg, src_high_byte, src_width_bytes,
		       immediate_value,
		input  ready
	);

	modport sink (
		input  valid, operation, dest_reg, dest_high_byte, dest_width_bytes,
		       src_is_immediate, src_reg, src_high_byte, src_width_bytes,
		       immediate_value,
		output ready
	);

endinterface

// ===== hdl/rfae_rsp_if.sv =====
// rfae_rsp_if: result channel, valid/ready plus destination words and flags
// depends on rfae_pkg
interface rfae_rsp_if;

	logic                       valid;
	logic                       ready;
	logic [rfae_pkg::WordW-1:0] value_before;
	logic [rfae_pkg::WordW-1:0] value_after;
	logic                       zero_flag;
	logic                       sign_flag;

	modport source (
		output valid, value_before, value_after, zero_flag, sign_flag,
		input  ready
	);

	modport sink (
		input  valid, value_before, value_after, zero_flag, sign_flag,
		output ready
	);

endinterface

// ===== hdl/rfae_regfile.sv =====
// rfae_regfile: thirteen-word register file, one write port, two registered read ports
// per-entry valid bits make unwritten entries and out-of-range indexes read as zero
// depends on rfae_pkg
module rfae_regfile (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [rfae_pkg::RegIdxW-1:0]  rd_a_idx,
	input  logic [rfae_pkg::RegIdxW-1:0]  rd_b_idx,
	output logic [rfae_pkg::WordW-1:0]    rd_a_word,
	output logic [rfae_pkg::WordW-1:0]    rd_b_word,
	input  rfae_pkg::wr_t                 wr
);

	logic [rfae_pkg::WordW-1:0]   mem [rfae_pkg::NumRegs];
	logic [rfae_pkg::NumRegs-1:0] ent_vld_q;
	logic [rfae_pkg::WordW-1:0]   rd_a_data_q;
	logic [rfae_pkg::WordW-1:0]   rd_b_data_q;
	logic                         rd_a_hit_q;
	logic                         rd_b_hit_q;
	logic                         a_in_range;
	logic                         b_in_range;

	assign a_in_range = rd_a_idx < rfae_pkg::RegIdxW'(rfae_pkg::NumRegs);
	assign b_in_range = rd_b_idx < rfae_pkg::RegIdxW'(rfae_pkg::NumRegs);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.word;
		end
		if (rd_en) begin
			rd_a_data_q <= mem[rd_a_idx];
			rd_b_data_q <= mem[rd_b_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q  <= '0;
			rd_a_hit_q <= 1'b0;
			rd_b_hit_q <= 1'b0;
		end else begin
			if (wr.en) begin
				ent_vld_q[wr.idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_a_hit_q <= a_in_range && ent_vld_q[rd_a_idx];
				rd_b_hit_q <= b_in_range && ent_vld_q[rd_b_idx];
			end
		end
	end

	assign rd_a_word = rd_a_hit_q ? rd_a_data_q : '0;
	assign rd_b_word = rd_b_hit_q ? rd_b_data_q : '0;

endmodule

// ===== hdl/rfae_alu.sv =====
// rfae_alu: operand selection, add/subtract, byte merge and flag update for one instruction
// combinational; depends on rfae_pkg
module rfae_alu (
	input  rfae_pkg::item_t                 item,
	input  logic [rfae_pkg::WordW-1:0]      dst_word,
	input  logic [rfae_pkg::WordW-1:0]      src_word,
	input  logic [rfae_pkg::FlagW-1:0]      flags,
	output rfae_pkg::wr_t                   wr,
	output logic [rfae_pkg::WordW-1:0]      after_word,
	output logic [rfae_pkg::FlagW-1:0]      flags_new
);

	logic                       dword;
	logic                       sword;
	logic [rfae_pkg::WordW-1:0] mask;
	logic [rfae_pkg::WordW-1:0] lhs;
	logic [rfae_pkg::WordW-1:0] src_part;
	logic [rfae_pkg::WordW-1:0] rhs;
	logic [rfae_pkg::WordW-1:0] res;
	logic [rfae_pkg::WordW-1:0] value;
	logic [rfae_pkg::WordW-1:0] merged;
	logic                       in_range;

	always_comb begin
		dword = item.dest_width_bytes[1];
		sword = item.src_width_bytes[1];
		mask  = dword ? '1 : rfae_pkg::WordW'({rfae_pkg::ByteW{1'b1}});

		if (dword) begin
			lhs = dst_word;
		end else if (item.dest_high_byte) begin
			lhs = rfae_pkg::WordW'(dst_word[rfae_pkg::WordW-1:rfae_pkg::ByteW]);
		end else begin
			lhs = rfae_pkg::WordW'(dst_word[rfae_pkg::ByteW-1:0]);
		end

		if (sword) begin
			src_part = src_word;
		end else if (item.src_high_byte) begin
			src_part = rfae_pkg::WordW'(src_word[rfae_pkg::WordW-1:rfae_pkg::ByteW]);
		end else begin
			src_part = rfae_pkg::WordW'(src_word[rfae_pkg::ByteW-1:0]);
		end

		rhs = (item.src_is_immediate ? item.immediate_value : src_part) & mask;

		if (item.operation == rfae_pkg::OpAdd) begin
			res = (lhs + rhs) & mask;
		end else begin
			res = (lhs - rhs) & mask;
		end

		value = (item.operation == rfae_pkg::OpMov) ? rhs : res;

		if (dword) begin
			merged = value;
		end else if (item.dest_high_byte) begin
			merged = {value[rfae_pkg::ByteW-1:0], dst_word[rfae_pkg::ByteW-1:0]};
		end else begin
			merged = {dst_word[rfae_pkg::WordW-1:rfae_pkg::ByteW], value[rfae_pkg::ByteW-1:0]};
		end

		in_range = item.dest_reg < rfae_pkg::RegIdxW'(rfae_pkg::NumRegs);

		wr.en   = in_range && (item.operation != rfae_pkg::OpCmp);
		wr.idx  = item.dest_reg;
		wr.word = merged;

		after_word = wr.en ? merged : dst_word;

		if (item.operation == rfae_pkg::OpMov) begin
			flags_new = flags;
		end else begin
			flags_new[rfae_pkg::FlagZeroBit] = (res == '0);
			flags_new[rfae_pkg::FlagSignBit] =
				dword ? res[rfae_pkg::WordW-1] : res[rfae_pkg::ByteW-1];
		end
	end

endmodule

// ===== hdl/register_file_alu_exec.sv =====
// register_file_alu_exec: top level of the mov/add/sub/cmp execute block
// depends on rfae_pkg, rfae_req_if, rfae_rsp_if, rfae_regfile, rfae_alu
//
// usage
//   req carries one decoded instruction per transfer (operation, destination and
//   source register selects with byte/word access, immediate). rsp returns one
//   result per instruction: destination word before and after, zero and sign flags.
//   results leave in instruction order, exactly one per accepted instruction.
// pipeline and throughput
//   an accepted instruction is registered in the execute stage, then its result in the
//   result register driving rsp. one instruction per cycle is sustained while rsp is
//   taken; the register file read is registered at acceptance and the word written back
//   by the instruction ahead is forwarded to the next, so dependent ones run back to back.
// reset
//   arst_n clears all thirteen registers (per-entry valid bits), the flags and the
//   pipeline; req.ready is high right after reset.
// stalls
//   when rsp is not taken, the result register holds, the instruction in the
//   execute stage waits, and req.ready drops once that stage is also occupied.
module register_file_alu_exec (
	input  logic       clk,
	input  logic       arst_n,
	rfae_req_if.sink   req,
	rfae_rsp_if.source rsp
);

	logic                          accept;
	logic                          adv;
	logic                          valid_s1;
	rfae_pkg::item_t               item_s1;
	rfae_pkg::item_t               item_in;
	logic [rfae_pkg::WordW-1:0]    dst_rd;
	logic [rfae_pkg::WordW-1:0]    src_rd;
	logic [rfae_pkg::WordW-1:0]    dst_word;
	logic [rfae_pkg::WordW-1:0]    src_word;
	rfae_pkg::wr_t                 fwd_q;
	rfae_pkg::wr_t                 wr;
	logic [rfae_pkg::FlagW-1:0]    flags_q;
	logic [rfae_pkg::FlagW-1:0]    flags_new;
	logic [rfae_pkg::WordW-1:0]    after_word;
	logic                          out_valid_q;
	logic [rfae_pkg::WordW-1:0]    before_q;
	logic [rfae_pkg::WordW-1:0]    after_q;
	logic [rfae_pkg::FlagW-1:0]    out_flags_q;
	rfae_pkg::wr_t                 wr_gated;

	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign accept    = req.valid && req.ready;

	always_comb begin
		item_in.operation        = rfae_pkg::op_t'(req.operation);
		item_in.dest_reg         = req.dest_reg;
		item_in.dest_high_byte   = req.dest_high_byte;
		item_in.dest_width_bytes = req.dest_width_bytes;
		item_in.src_is_immediate = req.src_is_immediate;
		item_in.src_reg          = req.src_reg;
		item_in.src_high_byte    = req.src_high_byte;
		item_in.src_width_bytes  = req.src_width_bytes;
		item_in.immediate_value  = req.immediate_value;
	end

	rfae_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_a_idx  (req.dest_reg),
		.rd_b_idx  (req.src_reg),
		.rd_a_word (dst_rd),
		.rd_b_word (src_rd),
		.wr        (wr_gated)
	);

	// forward the last word written back, which covers a write at the edge this instruction was read
	assign dst_word = (fwd_q.en && (fwd_q.idx == item_s1.dest_reg)) ? fwd_q.word : dst_rd;
	assign src_word = (fwd_q.en && (fwd_q.idx == item_s1.src_reg)) ? fwd_q.word : src_rd;

	rfae_alu u_alu (
		.item       (item_s1),
		.dst_word   (dst_word),
		.src_word   (src_word),
		.flags      (flags_q),
		.wr         (wr),
		.after_word (after_word),
		.flags_new  (flags_new)
	);

	always_comb begin
		wr_gated    = wr;
		wr_gated.en = wr.en && adv;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
		if (adv) begin
			before_q    <= dst_word;
			after_q     <= after_word;
			out_flags_q <= flags_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
			fwd_q       <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= accept;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				flags_q     <= flags_new;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_gated.en) begin
				fwd_q <= wr_gated;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.value_before = before_q;
	assign rsp.value_after  = after_q;
	assign rsp.zero_flag    = out_flags_q[rfae_pkg::FlagZeroBit];
	assign rsp.sign_flag    = out_flags_q[rfae_pkg::FlagSignBit];

endmodule
